// File: src/spcl_pkg.sv
// Package: field widths, result codes and the control store of the slot pool sequencer.
package spcl_pkg;

  localparam int unsigned KIND_W          = 3;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned SLOT_W          = 8;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned LIVE_W          = 8;
  localparam int unsigned LIVE_MAX        = (1 << LIVE_W) - 1;
  localparam int unsigned DEF_TOTAL_SLOTS = 256;
  localparam int unsigned DEF_HEAD_SLOTS  = 1;
  localparam int unsigned UPC_W           = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD, KIND_DELETE, KIND_RELEASE, KIND_COMPACT, KIND_COUNT, KIND_CLEAR
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {ST_OK, ST_FULL, ST_ABSENT, ST_RANGE} status_e;

  typedef enum logic [2:0] {
    C_NEVER, C_STEPS_END, C_SCAN_STOP, C_USED_CLR, C_USED_SET, C_WALK_END, C_WALK_HIT,
    C_IDX_BAD
  } cond_e;

  typedef enum logic [1:0] {N_SEQ, N_HOLD, N_JUMP} nxt_e;
  typedef enum logic [1:0] {S_KEEP, S_ZERO, S_HEAD, S_INC} steps_op_e;
  typedef enum logic [1:0] {P_KEEP, P_STEPS, P_LINK} ptr_op_e;
  typedef enum logic [1:0] {V_KEEP, V_ZERO, V_PTR} prev_op_e;
  typedef enum logic [1:0] {T_KEEP, T_ZERO, T_PTR, T_PREV_IF_END} tail_op_e;
  typedef enum logic [1:0] {LR_NONE, LR_ZERO, LR_PTR, LR_LINK} lrd_e;
  typedef enum logic [1:0] {UR_NONE, UR_STEPS, UR_PTR} urd_e;
  typedef enum logic [2:0] {
    LW_NONE, LW_PTR_END, LW_TAIL_PTR, LW_PREV_LINK, LW_STEPS_INIT
  } lwr_e;
  typedef enum logic [2:0] {
    UW_NONE, UW_PTR_SET, UW_PTR_CLR, UW_IDX_CLR, UW_STEPS_CLR
  } uwr_e;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    cond_e     cond;
    upc_t      tgt;
    nxt_e      nxt;
    steps_op_e steps_op;
    ptr_op_e   ptr_op;
    prev_op_e  prev_op;
    tail_op_e  tail_op;
    lrd_e      lrd;
    urd_e      urd;
    lwr_e      lwr;
    uwr_e      uwr;
    logic      fin;
    status_e   status;
    logic      out_slot;
    logic      out_live;
  } ctrl_t;

  typedef struct packed {
    logic steps_end;
    logic used_clr;
    logic walk_end;
    logic ptr_hit;
    logic idx_bad;
  } flags_t;

  localparam upc_t UA_CLR0   = 5'd0;
  localparam upc_t UA_CLR1   = 5'd1;
  localparam upc_t UA_CLR2   = 5'd2;
  localparam upc_t UA_ADD0   = 5'd3;
  localparam upc_t UA_ADD1   = 5'd4;
  localparam upc_t UA_ADD2   = 5'd5;
  localparam upc_t UA_ADD3   = 5'd6;
  localparam upc_t UA_FULL   = 5'd7;
  localparam upc_t UA_ADD4   = 5'd8;
  localparam upc_t UA_ADD5   = 5'd9;
  localparam upc_t UA_DEL0   = 5'd10;
  localparam upc_t UA_DEL1   = 5'd11;
  localparam upc_t UA_DEL2   = 5'd12;
  localparam upc_t UA_DEL3   = 5'd13;
  localparam upc_t UA_DEL4   = 5'd14;
  localparam upc_t UA_ABSENT = 5'd15;
  localparam upc_t UA_RANGE  = 5'd16;
  localparam upc_t UA_REL0   = 5'd17;
  localparam upc_t UA_CMP0   = 5'd18;
  localparam upc_t UA_CMP1   = 5'd19;
  localparam upc_t UA_CMP2   = 5'd20;
  localparam upc_t UA_CMP3   = 5'd21;
  localparam upc_t UA_CMP4   = 5'd22;
  localparam upc_t UA_CMP5   = 5'd23;
  localparam upc_t UA_CNT0   = 5'd24;
  localparam upc_t UA_CNT1   = 5'd25;
  localparam upc_t UA_CNT2   = 5'd26;
  localparam upc_t UA_CNT3   = 5'd27;
  localparam upc_t UA_NOP    = 5'd28;

  localparam ctrl_t UC_IDLE = '{
    cond: C_NEVER, tgt: '0, nxt: N_SEQ, steps_op: S_KEEP, ptr_op: P_KEEP,
    prev_op: V_KEEP, tail_op: T_KEEP, lrd: LR_NONE, urd: UR_NONE, lwr: LW_NONE,
    uwr: UW_NONE, fin: 1'b0, status: ST_OK, out_slot: 1'b0, out_live: 1'b0
  };

  function automatic upc_t entry(input logic [KIND_W-1:0] k);
    upc_t a;
    unique case (kind_e'(k))
      KIND_ADD:     a = UA_ADD0;
      KIND_DELETE:  a = UA_DEL0;
      KIND_RELEASE: a = UA_REL0;
      KIND_COMPACT: a = UA_CMP0;
      KIND_COUNT:   a = UA_CNT0;
      KIND_CLEAR:   a = UA_CLR0;
      default:      a = UA_NOP;
    endcase
    return a;
  endfunction

  // Control store. A word whose condition holds jumps and does nothing else.
  function automatic ctrl_t ucode(input upc_t addr);
    ctrl_t w;
    w = UC_IDLE;
    unique case (addr)
      UA_CLR0: begin
        w.steps_op = S_ZERO;
      end
      UA_CLR1: begin
        w.cond = C_STEPS_END; w.tgt = UA_CLR2; w.nxt = N_HOLD;
        w.steps_op = S_INC; w.lwr = LW_STEPS_INIT; w.uwr = UW_STEPS_CLR;
      end
      UA_CLR2: begin
        w.tail_op = T_ZERO; w.fin = 1'b1;
      end
      UA_ADD0: begin
        w.steps_op = S_HEAD;
      end
      UA_ADD1: begin
        w.cond = C_STEPS_END; w.tgt = UA_FULL;
        w.urd = UR_STEPS; w.ptr_op = P_STEPS; w.steps_op = S_INC;
      end
      UA_ADD2: begin
        w.cond = C_SCAN_STOP; w.tgt = UA_ADD3; w.nxt = N_HOLD;
        w.urd = UR_STEPS; w.ptr_op = P_STEPS; w.steps_op = S_INC;
      end
      UA_ADD3: begin
        w.cond = C_USED_CLR; w.tgt = UA_ADD4;
      end
      UA_FULL: begin
        w.fin = 1'b1; w.status = ST_FULL;
      end
      UA_ADD4: begin
        w.lwr = LW_PTR_END; w.uwr = UW_PTR_SET;
      end
      UA_ADD5: begin
        w.lwr = LW_TAIL_PTR; w.tail_op = T_PTR; w.fin = 1'b1; w.out_slot = 1'b1;
      end
      UA_DEL0: begin
        w.cond = C_IDX_BAD; w.tgt = UA_RANGE;
        w.lrd = LR_ZERO; w.prev_op = V_ZERO; w.steps_op = S_ZERO;
      end
      UA_DEL1: begin
        w.ptr_op = P_LINK; w.lrd = LR_LINK;
      end
      UA_DEL2: begin
        w.cond = C_WALK_HIT; w.tgt = UA_DEL3; w.nxt = N_HOLD;
        w.prev_op = V_PTR; w.ptr_op = P_LINK; w.lrd = LR_LINK; w.steps_op = S_INC;
      end
      UA_DEL3: begin
        w.cond = C_WALK_END; w.tgt = UA_ABSENT;
      end
      UA_DEL4: begin
        w.lwr = LW_PREV_LINK; w.tail_op = T_PREV_IF_END; w.uwr = UW_PTR_CLR;
        w.fin = 1'b1;
      end
      UA_ABSENT: begin
        w.fin = 1'b1; w.status = ST_ABSENT;
      end
      UA_RANGE: begin
        w.fin = 1'b1; w.status = ST_RANGE;
      end
      UA_REL0: begin
        w.cond = C_IDX_BAD; w.tgt = UA_RANGE; w.uwr = UW_IDX_CLR; w.fin = 1'b1;
      end
      UA_CMP0: begin
        w.lrd = LR_ZERO; w.prev_op = V_ZERO; w.steps_op = S_ZERO;
      end
      UA_CMP1: begin
        w.ptr_op = P_LINK;
      end
      UA_CMP2: begin
        w.cond = C_WALK_END; w.tgt = UA_CNT0; w.lrd = LR_PTR; w.urd = UR_PTR;
      end
      UA_CMP3: begin
        w.cond = C_USED_SET; w.tgt = UA_CMP5;
      end
      UA_CMP4: begin
        w.lwr = LW_PREV_LINK; w.tail_op = T_PREV_IF_END; w.ptr_op = P_LINK;
        w.steps_op = S_INC; w.nxt = N_JUMP; w.tgt = UA_CMP2;
      end
      UA_CMP5: begin
        w.prev_op = V_PTR; w.ptr_op = P_LINK; w.steps_op = S_INC;
        w.nxt = N_JUMP; w.tgt = UA_CMP2;
      end
      UA_CNT0: begin
        w.lrd = LR_ZERO; w.steps_op = S_ZERO;
      end
      UA_CNT1: begin
        w.ptr_op = P_LINK; w.lrd = LR_LINK;
      end
      UA_CNT2: begin
        w.cond = C_WALK_END; w.tgt = UA_CNT3; w.nxt = N_HOLD;
        w.ptr_op = P_LINK; w.lrd = LR_LINK; w.steps_op = S_INC;
      end
      UA_CNT3: begin
        w.fin = 1'b1; w.out_live = 1'b1;
      end
      UA_NOP: begin
        w.fin = 1'b1;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/spcl_req_if.sv
// Request channel: operation kind and slot index.
interface spcl_req_if;
  import spcl_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  slot_index;

  modport source (output valid, kind, slot_index, input ready);
  modport sink (input valid, kind, slot_index, output ready);
endinterface

// File: src/spcl_rsp_if.sv
// Response channel: allocated slot, status and list length.
interface spcl_rsp_if;
  import spcl_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status;
  logic [LIVE_W-1:0]   live_count;

  modport source (output valid, slot, status, live_count, input ready);
  modport sink (input valid, slot, status, live_count, output ready);
endinterface

// File: src/slot_pool_circular_list_top.sv
// Top level: slot pool with one circular linked list, microcoded datapath and tables.
//
//   channel | dir | transfer moves
//   --------+-----+-------------------------------
//   req_i   | in  | kind, slot_index
//   rsp_o   | out | slot, status, live_count
//
// One request at a time; every request gives one response.
// Add scans the used marks from HEAD_SLOTS upward, one slot scanned per cycle.
// Delete and count walk the list from the head node.
// Compact walks the list, then ends with a count; clear writes one entry a cycle.
// After reset the same clearing pass runs with req_i.ready low.
// A new request is taken while a response waits; the next response waits for rsp_o.ready.
module slot_pool_circular_list_top #(
  parameter int unsigned TOTAL_SLOTS = spcl_pkg::DEF_TOTAL_SLOTS,
  parameter int unsigned HEAD_SLOTS  = spcl_pkg::DEF_HEAD_SLOTS
) (
  input logic       clk_i,
  input logic       rst_ni,
  spcl_req_if.sink   req_i,
  spcl_rsp_if.source rsp_o
);
  import spcl_pkg::*;

  localparam int unsigned AW = $clog2(TOTAL_SLOTS);
  localparam int unsigned SW = $clog2(TOTAL_SLOTS + HEAD_SLOTS + 1);

  ctrl_t  ctrl;
  flags_t flags;
  logic   exec;
  logic   busy;
  logic   start;

  logic [AW-1:0]       ptr_q, prev_q, tail_q;
  logic [SW-1:0]       steps_q;
  logic [IDX_W-1:0]    idx_q;
  logic                silent_q;
  logic [AW-1:0]       link_rd_q;
  logic                used_rd_q;
  logic                out_valid_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [LIVE_W-1:0]   out_live_q;

  logic [AW-1:0] link_mem [TOTAL_SLOTS];
  logic          used_mem [TOTAL_SLOTS];

  logic [AW-1:0] steps_addr, idx_addr, init_data;
  logic          steps_end;
  logic          link_re, link_we, used_re, used_we, used_wdata;
  logic [AW-1:0] link_raddr, link_waddr, link_wdata, used_raddr, used_waddr;

  assign start      = req_i.valid && !busy;
  assign steps_addr = steps_q[AW-1:0];
  assign idx_addr   = AW'(idx_q);
  assign init_data  = (32'(steps_q) < HEAD_SLOTS) ? steps_addr : '0;
  assign steps_end  = 32'(steps_q) >= TOTAL_SLOTS;

  assign flags.steps_end = steps_end;
  assign flags.used_clr  = !used_rd_q;
  assign flags.walk_end  = (ptr_q == '0) || steps_end;
  assign flags.ptr_hit   = 32'(ptr_q) == 32'(idx_q);
  assign flags.idx_bad   = (32'(idx_q) < HEAD_SLOTS) || (32'(idx_q) >= TOTAL_SLOTS);

  spcl_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (req_i.kind),
    .flags_i (flags),
    .hold_i  (out_valid_q && !rsp_o.ready),
    .ctrl_o  (ctrl),
    .exec_o  (exec),
    .busy_o  (busy)
  );

  assign req_i.ready = !busy;

  // table ports
  always_comb begin
    link_re    = exec && (ctrl.lrd != LR_NONE);
    link_raddr = '0;
    unique case (ctrl.lrd)
      LR_PTR:  link_raddr = ptr_q;
      LR_LINK: link_raddr = link_rd_q;
      default: link_raddr = '0;
    endcase
  end

  always_comb begin
    used_re    = exec && (ctrl.urd != UR_NONE);
    used_raddr = (ctrl.urd == UR_PTR) ? ptr_q : steps_addr;
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = ptr_q;
    link_wdata = '0;
    unique case (ctrl.lwr)
      LW_PTR_END: begin
        link_we = exec;
      end
      LW_TAIL_PTR: begin
        link_we = exec; link_waddr = tail_q; link_wdata = ptr_q;
      end
      LW_PREV_LINK: begin
        link_we = exec; link_waddr = prev_q; link_wdata = link_rd_q;
      end
      LW_STEPS_INIT: begin
        link_we = exec; link_waddr = steps_addr; link_wdata = init_data;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    used_we    = 1'b0;
    used_waddr = ptr_q;
    used_wdata = 1'b0;
    unique case (ctrl.uwr)
      UW_PTR_SET: begin
        used_we = exec; used_wdata = 1'b1;
      end
      UW_PTR_CLR: begin
        used_we = exec;
      end
      UW_IDX_CLR: begin
        used_we = exec; used_waddr = idx_addr;
      end
      UW_STEPS_CLR: begin
        used_we = exec; used_waddr = steps_addr;
      end
      default: begin
        used_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
    if (used_re) begin
      used_rd_q <= used_mem[used_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      idx_q <= req_i.slot_index;
    end
  end

  // walk and scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      prev_q   <= '0;
      tail_q   <= '0;
      steps_q  <= '0;
      silent_q <= 1'b1;
    end else begin
      if (start) begin
        silent_q <= 1'b0;
      end
      if (exec) begin
        unique case (ctrl.steps_op)
          S_ZERO:  steps_q <= '0;
          S_HEAD:  steps_q <= SW'(HEAD_SLOTS);
          S_INC:   steps_q <= steps_q + SW'(1);
          default: steps_q <= steps_q;
        endcase
        unique case (ctrl.ptr_op)
          P_STEPS: ptr_q <= steps_addr;
          P_LINK:  ptr_q <= link_rd_q;
          default: ptr_q <= ptr_q;
        endcase
        unique case (ctrl.prev_op)
          V_ZERO:  prev_q <= '0;
          V_PTR:   prev_q <= ptr_q;
          default: prev_q <= prev_q;
        endcase
        unique case (ctrl.tail_op)
          T_ZERO: tail_q <= '0;
          T_PTR:  tail_q <= ptr_q;
          T_PREV_IF_END: begin
            if (link_rd_q == '0) begin
              tail_q <= prev_q;
            end
          end
          default: tail_q <= tail_q;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec && ctrl.fin && !silent_q) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && ctrl.fin && !silent_q) begin
      out_slot_q   <= ctrl.out_slot ? SLOT_W'(ptr_q) : '0;
      out_status_q <= ctrl.status;
      if (!ctrl.out_live) begin
        out_live_q <= '0;
      end else if (32'(steps_q) > LIVE_MAX) begin
        out_live_q <= LIVE_W'(LIVE_MAX);
      end else begin
        out_live_q <= LIVE_W'(steps_q);
      end
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.slot       = out_slot_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.live_count = out_live_q;

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !link_we && !used_we)
    else $error("table written while idle");

  a_tail_not_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q == '0) || (32'(tail_q) >= HEAD_SLOTS))
    else $error("tail points at a reserved head");

  a_link_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_we |-> 32'(link_wdata) < TOTAL_SLOTS)
    else $error("link written beyond table");

  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == ST_FULL) |-> (out_slot_q == '0) && (out_live_q == '0))
    else $error("full response carries data");
`endif

endmodule

// File: src/spcl_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module spcl_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [spcl_pkg::KIND_W-1:0] kind_i,
  input  spcl_pkg::flags_t            flags_i,
  input  logic                        hold_i,
  output spcl_pkg::ctrl_t             ctrl_o,
  output logic                        exec_o,
  output logic                        busy_o
);
  import spcl_pkg::*;

  upc_t  upc_q, upc_d;
  logic  busy_q, busy_d;
  logic  cond_true;
  logic  jump;
  logic  stall;
  ctrl_t w;

  assign w      = ucode(upc_q);
  assign ctrl_o = w;
  assign busy_o = busy_q;

  always_comb begin
    unique case (w.cond)
      C_NEVER:     cond_true = 1'b0;
      C_STEPS_END: cond_true = flags_i.steps_end;
      C_SCAN_STOP: cond_true = flags_i.used_clr || flags_i.steps_end;
      C_USED_CLR:  cond_true = flags_i.used_clr;
      C_USED_SET:  cond_true = !flags_i.used_clr;
      C_WALK_END:  cond_true = flags_i.walk_end;
      C_WALK_HIT:  cond_true = flags_i.walk_end || flags_i.ptr_hit;
      C_IDX_BAD:   cond_true = flags_i.idx_bad;
      default:     cond_true = 1'b0;
    endcase
  end

  // a finishing step waits while the previous result is still unclaimed
  assign stall  = w.fin && hold_i;
  assign jump   = busy_q && cond_true;
  assign exec_o = busy_q && !cond_true && !stall;

  always_comb begin
    upc_d  = upc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        upc_d  = entry(kind_i);
        busy_d = 1'b1;
      end
    end else if (jump) begin
      upc_d = w.tgt;
    end else if (exec_o) begin
      if (w.fin) begin
        busy_d = 1'b0;
      end else begin
        unique case (w.nxt)
          N_SEQ:   upc_d = upc_q + UPC_W'(1);
          N_HOLD:  upc_d = upc_q;
          N_JUMP:  upc_d = w.tgt;
          default: upc_d = upc_q;
        endcase
      end
    end
  end

  // reset runs the clear routine before the first request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= UA_CLR0;
      busy_q <= 1'b1;
    end else begin
      upc_q  <= upc_d;
      busy_q <= busy_d;
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Testbench: slot pool circular list, random and directed requests checked against a mirror.

typedef struct packed {
  logic [spcl_pkg::SLOT_W-1:0] slot;
  spcl_pkg::status_e           status;
  logic [spcl_pkg::LIVE_W-1:0] live;
} pool_rsp_t;

class pool_mirror;
  bit [spcl_pkg::IDX_W-1:0] next_of [spcl_pkg::DEF_TOTAL_SLOTS];
  bit                       used [spcl_pkg::DEF_TOTAL_SLOTS];
  bit [spcl_pkg::IDX_W-1:0] tail;
  pool_rsp_t                awaited [$];
  int unsigned              mismatches;
  int unsigned              answered;

  function new();
    wipe();
    mismatches = 0;
    answered = 0;
  endfunction

  function void wipe();
    for (int i = 0; i < spcl_pkg::DEF_TOTAL_SLOTS; i++) begin
      next_of[i] = '0;
      used[i] = 1'b0;
    end
    for (int i = 0; i < spcl_pkg::DEF_HEAD_SLOTS; i++) next_of[i] = 8'(i);
    tail = '0;
  endfunction

  function bit out_of_range(int unsigned idx);
    return idx < spcl_pkg::DEF_HEAD_SLOTS || idx >= spcl_pkg::DEF_TOTAL_SLOTS;
  endfunction

  function int unsigned walk_length();
    int unsigned n;
    int unsigned p;
    n = 0;
    p = next_of[0];
    while (p != 0 && n < spcl_pkg::DEF_TOTAL_SLOTS) begin
      n++;
      p = next_of[p];
    end
    return (n > spcl_pkg::LIVE_MAX) ? spcl_pkg::LIVE_MAX : n;
  endfunction

  function spcl_pkg::status_e allocate(output bit [spcl_pkg::SLOT_W-1:0] got);
    got = '0;
    for (int i = spcl_pkg::DEF_HEAD_SLOTS; i < spcl_pkg::DEF_TOTAL_SLOTS; i++) begin
      if (!used[i]) begin
        used[i] = 1'b1;
        next_of[i] = '0;
        next_of[tail] = 8'(i);
        tail = 8'(i);
        got = 8'(i);
        return spcl_pkg::ST_OK;
      end
    end
    return spcl_pkg::ST_FULL;
  endfunction

  function spcl_pkg::status_e unlink(int unsigned idx);
    int unsigned s;
    int unsigned p;
    int unsigned n;
    int unsigned steps;
    if (out_of_range(idx)) return spcl_pkg::ST_RANGE;
    s = 0;
    p = next_of[0];
    steps = 0;
    while (p != 0 && steps < spcl_pkg::DEF_TOTAL_SLOTS) begin
      if (p == idx) begin
        n = next_of[p];
        next_of[s] = 8'(n);
        if (n == 0) tail = 8'(s);
        used[p] = 1'b0;
        return spcl_pkg::ST_OK;
      end
      s = p;
      p = next_of[p];
      steps++;
    end
    return spcl_pkg::ST_ABSENT;
  endfunction

  // drops every linked slot whose used mark is clear
  function void sweep();
    int unsigned s;
    int unsigned p;
    int unsigned n;
    int unsigned steps;
    s = 0;
    p = next_of[0];
    steps = 0;
    while (p != 0 && steps < spcl_pkg::DEF_TOTAL_SLOTS) begin
      if (!used[p]) begin
        n = next_of[p];
        next_of[s] = 8'(n);
        if (n == 0) tail = 8'(s);
        p = n;
      end else begin
        s = p;
        p = next_of[p];
      end
      steps++;
    end
  endfunction

  function void note_request(bit [spcl_pkg::KIND_W-1:0] kind, bit [spcl_pkg::IDX_W-1:0] idx);
    pool_rsp_t r;
    bit [spcl_pkg::SLOT_W-1:0] got;
    r.slot = '0;
    r.status = spcl_pkg::ST_OK;
    r.live = '0;
    case (kind)
      spcl_pkg::KIND_ADD: begin
        r.status = allocate(got);
        r.slot = got;
      end
      spcl_pkg::KIND_DELETE: r.status = unlink(idx);
      spcl_pkg::KIND_RELEASE: begin
        if (out_of_range(idx)) r.status = spcl_pkg::ST_RANGE;
        else used[idx] = 1'b0;
      end
      spcl_pkg::KIND_COMPACT: begin
        sweep();
        r.live = 8'(walk_length());
      end
      spcl_pkg::KIND_COUNT: r.live = 8'(walk_length());
      spcl_pkg::KIND_CLEAR: wipe();
      default: ;
    endcase
    awaited.push_back(r);
  endfunction

  function void check_response(logic [spcl_pkg::SLOT_W-1:0] slot,
                               logic [spcl_pkg::STATUS_W-1:0] status,
                               logic [spcl_pkg::LIVE_W-1:0] live);
    pool_rsp_t r;
    answered++;
    if (awaited.size() == 0) begin
      $error("unrequested response: slot %0d status %0d live_count %0d", slot, status, live);
      mismatches++;
      return;
    end
    r = awaited.pop_front();
    if (slot !== r.slot) begin
      $error("slot: expected %0d, got %0d", r.slot, slot);
      mismatches++;
    end
    if (status !== r.status) begin
      $error("status: expected %0d, got %0d", r.status, status);
      mismatches++;
    end
    if (live !== r.live) begin
      $error("live_count: expected %0d, got %0d", r.live, live);
      mismatches++;
    end
  endfunction

  function bit [spcl_pkg::IDX_W-1:0] pick_linked();
    bit [spcl_pkg::IDX_W-1:0] nodes [$];
    int unsigned p;
    int unsigned steps;
    p = next_of[0];
    steps = 0;
    while (p != 0 && steps < spcl_pkg::DEF_TOTAL_SLOTS) begin
      nodes.push_back(8'(p));
      p = next_of[p];
      steps++;
    end
    if (nodes.size() == 0)
      return 8'($urandom_range(spcl_pkg::DEF_HEAD_SLOTS, spcl_pkg::DEF_TOTAL_SLOTS - 1));
    return nodes[$urandom_range(0, nodes.size() - 1)];
  endfunction

  function int unsigned free_slots();
    int unsigned n;
    n = 0;
    for (int i = spcl_pkg::DEF_HEAD_SLOTS; i < spcl_pkg::DEF_TOTAL_SLOTS; i++)
      if (!used[i]) n++;
    return n;
  endfunction
endclass

module testbench;
  import spcl_pkg::*;

  localparam bit [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam bit [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned HOLD_AT      = 100;
  localparam int unsigned HOLD_LEN     = 600;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned TAIL_WAIT    = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  spcl_req_if req_if ();
  spcl_rsp_if rsp_if ();

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left;
  bit          held;
  pool_mirror  mirror;

  slot_pool_circular_list_top #(
    .TOTAL_SLOTS(DEF_TOTAL_SLOTS),
    .HEAD_SLOTS (DEF_HEAD_SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // response side, with one long hold-off to back the pool up
  initial begin
    held = 1'b0;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        mirror.check_response(rsp_if.slot, rsp_if.status, rsp_if.live_count);
      if (!held && mirror.answered >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic send(input bit [KIND_W-1:0] k, input bit [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind <= k;
    req_if.slot_index <= idx;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    mirror.note_request(k, idx);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (mirror.awaited.size() != 0);
  endtask

  task automatic issue_mixed(input int unsigned add_pct);
    int unsigned r;
    bit [IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    idx = 8'($urandom_range(0, 255));
    if (r < add_pct) send(KIND_ADD, idx);
    else if (r < add_pct + 20)
      send(KIND_DELETE, ($urandom_range(0, 3) != 0) ? mirror.pick_linked() : idx);
    else if (r < add_pct + 32)
      send(KIND_RELEASE, ($urandom_range(0, 9) < 7) ? mirror.pick_linked() : idx);
    else if (r < add_pct + 40) send(KIND_COMPACT, idx);
    else if (r < add_pct + 50) send(KIND_COUNT, idx);
    else if (r < add_pct + 52) send($urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI, idx);
    else if (r < add_pct + 53) send(KIND_CLEAR, idx);
    else send(KIND_DELETE, mirror.pick_linked());
  endtask

  initial begin
    int unsigned n;
    mirror = new();
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.kind <= KIND_ADD;
    req_if.slot_index <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 32;
    snk_idle_pct = 77;

    // empty list, reserved head, unused kinds
    send(KIND_COUNT, 8'h00);
    send(KIND_COMPACT, 8'hFF);
    send(KIND_DELETE, 8'h00);
    send(KIND_RELEASE, 8'h00);
    send(KIND_DELETE, 8'h05);
    send(KIND_SPARE_LO, 8'hFF);
    send(KIND_SPARE_HI, 8'hAA);
    repeat (4) send(KIND_ADD, 8'h55);
    // released slot stays linked, then is taken again
    send(KIND_RELEASE, 8'h02);
    send(KIND_DELETE, 8'h03);
    send(KIND_COUNT, 8'h00);
    send(KIND_ADD, 8'h00);
    send(KIND_COUNT, 8'h00);
    send(KIND_COMPACT, 8'h00);
    send(KIND_DELETE, 8'hFF);
    send(KIND_RELEASE, 8'hFF);
    send(KIND_DELETE, 8'h01);
    send(KIND_ADD, 8'h00);
    send(KIND_CLEAR, 8'h00);
    send(KIND_COUNT, 8'h00);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 77 : 0;
      snk_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 32 : 0;
      n = 0;
      if (ph == 2) begin
        // fill the table, then run into it
        while (mirror.free_slots() != 0) begin
          if ($urandom_range(0, 9) != 0) send(KIND_ADD, 8'($urandom_range(0, 255)));
          else send($urandom_range(0, 1) ? KIND_COUNT : KIND_COMPACT, 8'($urandom_range(0, 255)));
          n++;
        end
        repeat (3) send(KIND_ADD, 8'($urandom_range(0, 255)));
        send(KIND_COUNT, 8'h00);
        n += 4;
      end
      while (n < RANDOM_ITEMS / 3) begin
        if ($urandom_range(0, 1) != 0) repeat (40) issue_mixed(55);
        else repeat (40) issue_mixed(25);
        n += 40;
      end
      drain();
    end

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
